// ===== hw/rtl/mbfe_pkg.sv =====
// ----------------------------------------------------------------------------
// Main/backup failover election package
// Shared types, codes and defaults for the election block and its units.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mbfe_pkg;

  // Default sizing of the peer table and the generation counter.
  localparam int MAX_PEERS_DEF = 16;
  localparam int GEN_BITS_DEF  = 16;

  // Role encoding.
  localparam logic ROLE_MAIN   = 1'b0;
  localparam logic ROLE_BACKUP = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_OWN_PRIORITY = 2'd0;
  localparam logic [1:0] CFG_SELF_ID      = 2'd1;
  localparam logic [1:0] CFG_LOCAL_HASH   = 2'd2;

  // Event codes.
  typedef enum logic [1:0] {
    REQ_PEER     = 2'd0,
    REQ_ENABLE   = 2'd1,
    REQ_ROLE     = 2'd2,
    REQ_TAKEOVER = 2'd3
  } req_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GSCAN,
    ST_GSET,
    ST_SCAN,
    ST_FIN
  } state_t;

  // Input beat.
  typedef struct packed {
    logic [1:0]  req_type;
    logic [3:0]  slot;
    logic        entry_valid;
    logic        entry_role;
    logic [15:0] entry_gen;
    logic [6:0]  entry_priority;
    logic [31:0] entry_id;
    logic [31:0] entry_hash;
    logic        new_value;
  } in_item_t;

  // Result beat.
  typedef struct packed {
    logic        cur_role;
    logic        standby;
    logic        taken_over;
    logic [15:0] gen_out;
    logic        conflict_flag;
    logic        mismatch_flag;
    logic        any_peer;
    logic [4:0]  peer_total;
    logic        announce;
    logic        demoted;
  } out_item_t;

  // Summary flags gathered by one pass over the peer table.
  typedef struct packed {
    logic has_main;   // a valid main peer exists
    logic loser;      // some main peer outranks this node
    logic bk_out;     // some backup peer outranks this node
    logic mm;         // some main peer has a differing known hash
  } scan_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mbfe_table.sv =====
// ----------------------------------------------------------------------------
// Peer table
// One write port and one registered read port; valid bits cleared at reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mbfe_table #(
  parameter int MAX_PEERS = 16,
  parameter int GEN_BITS  = 16,
  parameter int IW        = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                wr_en,
  input  wire logic [IW-1:0]       wr_addr,
  input  wire logic                wr_valid,
  input  wire logic                wr_role,
  input  wire logic [GEN_BITS-1:0] wr_gen,
  input  wire logic [6:0]          wr_pri,
  input  wire logic [31:0]         wr_id,
  input  wire logic [31:0]         wr_hash,
  input  wire logic [IW-1:0]       rd_addr,
  output logic                     rd_valid,
  output logic                     rd_role,
  output logic [GEN_BITS-1:0]      rd_gen,
  output logic [6:0]               rd_pri,
  output logic [31:0]              rd_id,
  output logic [31:0]              rd_hash
);

  logic [MAX_PEERS-1:0] vld_r;
  logic                 mem_role [MAX_PEERS];
  logic [GEN_BITS-1:0]  mem_gen  [MAX_PEERS];
  logic [6:0]           mem_pri  [MAX_PEERS];
  logic [31:0]          mem_id   [MAX_PEERS];
  logic [31:0]          mem_hash [MAX_PEERS];

  // Valid bits, one per entry.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= wr_valid;
    end
  end

  // Entry payload write.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_role[wr_addr] <= wr_role;
      mem_gen[wr_addr]  <= wr_gen;
      mem_pri[wr_addr]  <= wr_pri;
      mem_id[wr_addr]   <= wr_id;
      mem_hash[wr_addr] <= wr_hash;
    end
  end

  // Registered read.
  always_ff @(posedge clk) begin
    rd_valid <= vld_r[rd_addr];
    rd_role  <= mem_role[rd_addr];
    rd_gen   <= mem_gen[rd_addr];
    rd_pri   <= mem_pri[rd_addr];
    rd_id    <= mem_id[rd_addr];
    rd_hash  <= mem_hash[rd_addr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mbfe_scan.sv =====
// ----------------------------------------------------------------------------
// Peer scan unit
// Compares one entry per acc cycle against this node and accumulates flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mbfe_scan #(
  parameter int MAX_PEERS = 16,
  parameter int GEN_BITS  = 16,
  parameter int CW        = $clog2(MAX_PEERS + 1)
) (
  input  wire logic                clk,
  input  wire logic                clr,
  input  wire logic                acc,
  input  wire logic                e_valid,
  input  wire logic                e_role,
  input  wire logic [GEN_BITS-1:0] e_gen,
  input  wire logic [6:0]          e_pri,
  input  wire logic [31:0]         e_id,
  input  wire logic [31:0]         e_hash,
  input  wire logic [GEN_BITS-1:0] own_gen,
  input  wire logic [6:0]          own_pri,
  input  wire logic [31:0]         self_id,
  input  wire logic [31:0]         local_hash,
  output mbfe_pkg::scan_stat_t     stat,
  output logic [CW-1:0]            count,
  output logic [GEN_BITS-1:0]      max_gen
);
  import mbfe_pkg::*;

  scan_stat_t          stat_r, stat_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [GEN_BITS-1:0] max_r, max_nxt;
  logic                is_main, is_bk, pri_win, tie_lose;

  // Per-entry comparison against this node.
  always_comb begin
    is_main  = e_valid && (e_role == ROLE_MAIN);
    is_bk    = e_valid && (e_role == ROLE_BACKUP);
    pri_win  = e_pri < own_pri;
    tie_lose = (e_pri == own_pri) && (e_id < self_id);
    stat_nxt = stat_r;
    cnt_nxt  = cnt_r;
    max_nxt  = max_r;
    if (is_main) begin
      stat_nxt.has_main = 1'b1;
      if ((e_gen > own_gen) || ((e_gen == own_gen) && (pri_win || tie_lose))) begin
        stat_nxt.loser = 1'b1;
      end
      if ((e_hash != 32'd0) && (local_hash != 32'd0) && (e_hash != local_hash)) begin
        stat_nxt.mm = 1'b1;
      end
    end
    if (is_bk && (pri_win || tie_lose)) begin
      stat_nxt.bk_out = 1'b1;
    end
    if (e_valid) begin
      cnt_nxt = cnt_r + CW'(1);
      if (e_gen > max_r) begin
        max_nxt = e_gen;
      end
    end
  end

  // Accumulators.
  always_ff @(posedge clk) begin
    if (clr) begin
      stat_r <= '0;
      cnt_r  <= '0;
      max_r  <= '0;
    end else if (acc) begin
      stat_r <= stat_nxt;
      cnt_r  <= cnt_nxt;
      max_r  <= max_nxt;
    end
  end

  assign stat    = stat_r;
  assign count   = cnt_r;
  assign max_gen = max_r;

endmodule

`default_nettype wire

// ===== hw/rtl/main_backup_failover_election_unit.sv =====
// ----------------------------------------------------------------------------
// Main/backup failover election unit
// Keeps the peer table and this node's role, generation and flags.
// ----------------------------------------------------------------------------
// Sequence: an accepted event runs a table pass (ST_SCAN); ST_FIN then commits the
//   result beat once the output is free. A granted manual takeover first runs
//   ST_GSCAN and ST_GSET. in_stall holds off a new event until the current one commits;
//   the scan walks one entry per cycle through one read port.
// Reset: synchronous; clears role, flags, generation and all table valid bits.
`timescale 1ns / 1ps
`default_nettype none

module main_backup_failover_election_unit #(
  parameter int MAX_PEERS = mbfe_pkg::MAX_PEERS_DEF,
  parameter int GEN_BITS  = mbfe_pkg::GEN_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire mbfe_pkg::in_item_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output mbfe_pkg::out_item_t       out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [31:0]          cfg_data
);
  import mbfe_pkg::*;

  localparam int IW = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
  localparam int CW = $clog2(MAX_PEERS + 1);

  state_t              state_r, state_nxt;
  logic [CW-1:0]       idx_r, idx_nxt;
  req_t                req_r;
  logic                nv_r;
  logic [6:0]          own_pri_r;
  logic [31:0]         self_id_r, local_hash_r;
  logic                en_r, role_r, took_r, seen_r, conf_r, mm_r;
  logic                en_nxt, role_nxt, took_nxt, seen_nxt, conf_nxt, mm_nxt;
  logic [GEN_BITS-1:0] gen_r, gen_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_data_r, out_data_nxt;
  logic                ann, dem;
  logic                in_acc, wr_en, scan_clr, scan_acc, commit;

  logic                rd_valid, rd_role;
  logic [GEN_BITS-1:0] rd_gen, max_gen;
  logic [6:0]          rd_pri;
  logic [31:0]         rd_id, rd_hash;
  scan_stat_t          stat;
  logic [CW-1:0]       count;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign wr_en     = in_acc && (req_t'(in_data.req_type) == REQ_PEER)
                     && (32'(in_data.slot) < 32'(MAX_PEERS));

  // Peer table.
  mbfe_table #(.MAX_PEERS(MAX_PEERS), .GEN_BITS(GEN_BITS), .IW(IW)) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (wr_en),
    .wr_addr  (IW'(in_data.slot)),
    .wr_valid (in_data.entry_valid),
    .wr_role  (in_data.entry_role),
    .wr_gen   (GEN_BITS'(in_data.entry_gen)),
    .wr_pri   (in_data.entry_priority),
    .wr_id    (in_data.entry_id),
    .wr_hash  (in_data.entry_hash),
    .rd_addr  (idx_r[IW-1:0]),
    .rd_valid (rd_valid),
    .rd_role  (rd_role),
    .rd_gen   (rd_gen),
    .rd_pri   (rd_pri),
    .rd_id    (rd_id),
    .rd_hash  (rd_hash)
  );

  // Shared compare unit.
  mbfe_scan #(.MAX_PEERS(MAX_PEERS), .GEN_BITS(GEN_BITS), .CW(CW)) u_scan (
    .clk        (clk),
    .clr        (scan_clr),
    .acc        (scan_acc),
    .e_valid    (rd_valid),
    .e_role     (rd_role),
    .e_gen      (rd_gen),
    .e_pri      (rd_pri),
    .e_id       (rd_id),
    .e_hash     (rd_hash),
    .own_gen    (gen_r),
    .own_pri    (own_pri_r),
    .self_id    (self_id_r),
    .local_hash (local_hash_r),
    .stat       (stat),
    .count      (count),
    .max_gen    (max_gen)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_pri_r    <= 7'd1;
      self_id_r    <= '0;
      local_hash_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_OWN_PRIORITY: own_pri_r    <= cfg_data[6:0];
        CFG_SELF_ID:      self_id_r    <= cfg_data;
        CFG_LOCAL_HASH:   local_hash_r <= cfg_data;
        default:          ;
      endcase
    end
  end

  // Latched event.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r <= req_t'(in_data.req_type);
      nv_r  <= in_data.new_value;
    end
  end

  // Control and node state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      en_r        <= 1'b0;
      role_r      <= ROLE_MAIN;
      took_r      <= 1'b0;
      seen_r      <= 1'b0;
      conf_r      <= 1'b0;
      mm_r        <= 1'b0;
      gen_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      en_r        <= en_nxt;
      role_r      <= role_nxt;
      took_r      <= took_nxt;
      seen_r      <= seen_nxt;
      conf_r      <= conf_nxt;
      mm_r        <= mm_nxt;
      gen_r       <= gen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  // Sequencer and rule resolution.
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    scan_clr      = 1'b0;
    scan_acc      = 1'b0;
    commit        = 1'b0;
    en_nxt        = en_r;
    role_nxt      = role_r;
    took_nxt      = took_r;
    seen_nxt      = seen_r;
    conf_nxt      = conf_r;
    mm_nxt        = mm_r;
    gen_nxt       = gen_r;
    ann           = 1'b0;
    dem           = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    case (state_r)
      ST_IDLE: begin
        scan_clr = 1'b1;
        idx_nxt  = '0;
        if (in_acc) begin
          if ((req_t'(in_data.req_type) == REQ_TAKEOVER) && en_r
              && (role_r == ROLE_BACKUP)) begin
            state_nxt = ST_GSCAN;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_GSCAN: begin
        scan_acc = (idx_r != '0);
        idx_nxt  = idx_r + CW'(1);
        if (idx_r == CW'(MAX_PEERS)) begin
          state_nxt = ST_GSET;
        end
      end
      ST_GSET: begin
        // Bump past the largest peer generation, saturating.
        gen_nxt   = (&max_gen) ? max_gen : max_gen + GEN_BITS'(1);
        scan_clr  = 1'b1;
        idx_nxt   = '0;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        scan_acc = (idx_r != '0);
        idx_nxt  = idx_r + CW'(1);
        if (idx_r == CW'(MAX_PEERS)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          commit    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (commit) begin
      // Event-specific updates before the shared rules.
      case (req_r)
        REQ_PEER: begin
          if (stat.has_main) begin
            seen_nxt = 1'b1;
          end
        end
        REQ_ENABLE: begin
          if (nv_r != en_r) begin
            en_nxt   = nv_r;
            took_nxt = 1'b0;
            seen_nxt = 1'b0;
          end
        end
        REQ_ROLE: begin
          if (nv_r != role_r) begin
            role_nxt = nv_r;
            if (nv_r == ROLE_BACKUP) begin
              took_nxt = 1'b0;
            end
          end
        end
        REQ_TAKEOVER: begin
          if (en_r && (role_r == ROLE_BACKUP)) begin
            took_nxt = 1'b1;
            role_nxt = ROLE_MAIN;
            ann      = 1'b1;
          end
        end
        default: ;
      endcase

      // Conflict rule: a main demotes itself when outranked.
      if (!((req_r == REQ_ENABLE) && (nv_r == en_r))
          && !((req_r == REQ_ROLE) && (nv_r == role_r))
          && !((req_r == REQ_TAKEOVER) && !(en_r && (role_r == ROLE_BACKUP)))) begin
        if (en_nxt && (role_nxt == ROLE_MAIN)) begin
          if (stat.has_main && stat.loser) begin
            conf_nxt = 1'b0;
            took_nxt = 1'b0;
            role_nxt = ROLE_BACKUP;
            dem      = 1'b1;
          end else begin
            conf_nxt = stat.has_main;
          end
        end else begin
          conf_nxt = 1'b0;
        end

        // Auto-promotion of a backup that lost sight of every main.
        if ((req_r == REQ_PEER) && en_nxt && (role_nxt == ROLE_BACKUP) && seen_nxt
            && !stat.has_main && !stat.bk_out) begin
          took_nxt = 1'b1;
          role_nxt = ROLE_MAIN;
          conf_nxt = 1'b0;
          ann      = 1'b1;
        end

        // Hash mismatch rule.
        mm_nxt = en_nxt && (role_nxt == ROLE_BACKUP) && stat.mm;
      end

      out_valid_nxt              = 1'b1;
      out_data_nxt.cur_role      = role_nxt;
      out_data_nxt.standby       = en_nxt && (role_nxt == ROLE_BACKUP) && !took_nxt;
      out_data_nxt.taken_over    = took_nxt;
      out_data_nxt.gen_out       = 16'(gen_nxt);
      out_data_nxt.conflict_flag = conf_nxt;
      out_data_nxt.mismatch_flag = mm_nxt;
      out_data_nxt.any_peer      = (count != '0);
      out_data_nxt.peer_total    = 5'(count);
      out_data_nxt.announce      = ann;
      out_data_nxt.demoted       = dem;
    end
  end

  // An accepted beat always starts a table pass.
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_GSCAN || state_r == ST_SCAN))
    else $error("accepted beat did not start a scan");

  // The conflict flag is only held by an enabled main.
  a_conf_main: assert property (@(posedge clk) disable iff (!rst_n)
    conf_r |-> (en_r && (role_r == ROLE_MAIN)))
    else $error("conflict flag set while not an enabled main");

  // The mismatch flag is only held by an enabled backup.
  a_mm_backup: assert property (@(posedge clk) disable iff (!rst_n)
    mm_r |-> (en_r && (role_r == ROLE_BACKUP)))
    else $error("mismatch flag set while not an enabled backup");

  // A standby result never reports the main role.
  a_standby_role: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.standby && (out_data_r.cur_role == ROLE_MAIN)))
    else $error("standby reported while main");

  // The generation only moves on the takeover bump.
  a_gen_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_GSET) |=> $stable(gen_r))
    else $error("generation changed outside a takeover");

endmodule

`default_nettype wire
